>>> sv/dir_cache_record_parser_assert.svh
// ----------------------------------------------------------------------------
// dir_cache_record_parser_assert.svh
// assertion macros shared by the directory-cache parser modules
// ----------------------------------------------------------------------------
`ifndef DIR_CACHE_RECORD_PARSER_ASSERT_SVH
`define DIR_CACHE_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DCRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dcrp assertion failed");

// next-cycle implication, disabled during reset
`define DCRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dcrp assertion failed");

`endif

>>> sv/dcrp_pkg.sv
// ----------------------------------------------------------------------------
// dcrp_pkg
// types, constants and helpers of the directory-cache record parser
// ----------------------------------------------------------------------------
package dcrp_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int NAME_MAX    = 30;

  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int SUM_W = OFF_W + 2;
  localparam int FIX_LEN = 20;
  localparam int REC_W = $clog2(FIX_LEN + NAME_MAX + 1);
  localparam int LEN_W = $clog2(NAME_MAX + 1);
  localparam int CNT_W = 31;

  // header byte positions
  localparam int POS_TYPE_END  = 3;
  localparam int POS_COUNT_END = 15;
  localparam int POS_NEXT_END  = 19;
  localparam int HDR_END       = 24;

  // record byte positions
  localparam int REC_HDR_END   = 3;
  localparam int REC_SIZE_END  = 7;
  localparam int REC_PROT_END  = 11;
  localparam int REC_DAYS_END  = 13;
  localparam int REC_MINS_END  = 15;
  localparam int REC_TICKS_END = 17;
  localparam int REC_KIND      = 18;
  localparam int REC_LEN       = 19;

  localparam logic [7:0] KIND_PLAIN_FILE = 8'hFD;
  localparam logic [7:0] KIND_DIRECTORY  = 8'h02;

  localparam logic [31:0] CACHE_TYPE_RESET = 32'd33;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_DONE = 2'd1,
    KIND_NEXT = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         name_char;
    logic [31:0]        header_block;
    logic [31:0]        file_size;
    logic [31:0]        protect_bits;
    logic signed [15:0] date_days;
    logic signed [15:0] date_mins;
    logic signed [15:0] date_ticks;
    logic signed [7:0]  entry_kind;
    logic               is_plain_file;
    logic               is_directory;
    logic [4:0]         name_length;
  } result_t;

  function automatic result_t make_summary(
    input logic [31:0]      hdr,
    input logic [31:0]      size,
    input logic [31:0]      prot,
    input logic [15:0]      days,
    input logic [15:0]      mins,
    input logic [15:0]      ticks,
    input logic [7:0]       ekind,
    input logic [LEN_W-1:0] len
  );
    result_t r;
    logic [LEN_W+4:0] len_x;
    r               = '0;
    len_x           = (LEN_W+5)'(len);
    r.kind          = KIND_DONE;
    r.header_block  = hdr;
    r.file_size     = size;
    r.protect_bits  = prot;
    r.date_days     = days;
    r.date_mins     = mins;
    r.date_ticks    = ticks;
    r.entry_kind    = ekind;
    r.is_plain_file = (ekind == KIND_PLAIN_FILE);
    r.is_directory  = (ekind == KIND_DIRECTORY);
    r.name_length   = len_x[4:0];
    return r;
  endfunction

endpackage

>>> sv/dcrp_parser.sv
// ----------------------------------------------------------------------------
// dcrp_parser
// per-byte block and record state, one result word at most per step
// ----------------------------------------------------------------------------
`include "dir_cache_record_parser_assert.svh"

module dcrp_parser import dcrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        block_start_i,
  input  logic [31:0] cache_block_type_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  logic [OFF_W-1:0] byte_offset_q, byte_offset_d;
  logic             block_bad_q, block_bad_d;
  logic [CNT_W-1:0] records_left_q, records_left_d;
  logic [REC_W-1:0] record_offset_q, record_offset_d;
  logic             done_pending_q, done_pending_d;
  logic [31:0]      word_shift_q, word_shift_d;
  logic [31:0]      hdr_q, hdr_d;
  logic [31:0]      size_q, size_d;
  logic [31:0]      prot_q, prot_d;
  logic [15:0]      days_q, days_d;
  logic [15:0]      mins_q, mins_d;
  logic [15:0]      ticks_q, ticks_d;
  logic [7:0]       ekind_q, ekind_d;
  logic [LEN_W-1:0] clamped_length_q, clamped_length_d;

  logic [OFF_W-1:0] pos;
  logic [LEN_W-1:0] len;
  logic [SUM_W-1:0] rec_end;
  logic [REC_W-1:0] name_end;

  always_comb begin
    byte_offset_d    = byte_offset_q;
    block_bad_d      = block_bad_q;
    records_left_d   = records_left_q;
    record_offset_d  = record_offset_q;
    done_pending_d   = done_pending_q;
    word_shift_d     = word_shift_q;
    hdr_d            = hdr_q;
    size_d           = size_q;
    prot_d           = prot_q;
    days_d           = days_q;
    mins_d           = mins_q;
    ticks_d          = ticks_q;
    ekind_d          = ekind_q;
    clamped_length_d = clamped_length_q;
    res_o            = '0;
    res_valid_o      = 1'b0;

    pos      = block_start_i ? '0 : byte_offset_q;
    len      = (data_byte_i > 8'(NAME_MAX)) ? LEN_W'(NAME_MAX) : LEN_W'(data_byte_i);
    rec_end  = SUM_W'(pos) + SUM_W'(1) + SUM_W'(len) + SUM_W'(len[0]);
    name_end = REC_W'(FIX_LEN) + REC_W'(clamped_length_q);

    if (step_i) begin
      // summary owed from the last name byte
      if (done_pending_q) begin
        res_o          = make_summary(hdr_q, size_q, prot_q, days_q, mins_q, ticks_q,
                                      ekind_q, clamped_length_q);
        res_valid_o    = 1'b1;
        done_pending_d = 1'b0;
      end

      if (pos == '0) begin
        block_bad_d     = 1'b0;
        records_left_d  = '0;
        record_offset_d = '0;
        word_shift_d    = {24'b0, data_byte_i};
      end else begin
        word_shift_d    = {word_shift_q[23:0], data_byte_i};
      end

      if (block_bad_d) begin
        // rest of a bad block ignored
      end else if (pos < OFF_W'(HDR_END)) begin
        if (pos == OFF_W'(POS_TYPE_END) && word_shift_d != cache_block_type_i) begin
          block_bad_d = 1'b1;
          res_o       = '0;
          res_o.kind  = KIND_BAD;
          res_valid_o = 1'b1;
        end else if (pos == OFF_W'(POS_COUNT_END)) begin
          records_left_d = word_shift_d[31] ? '0 : word_shift_d[CNT_W-1:0];
        end else if (pos == OFF_W'(POS_NEXT_END)) begin
          res_o              = '0;
          res_o.kind         = KIND_NEXT;
          res_o.header_block = word_shift_d;
          res_valid_o        = 1'b1;
        end
      end else if (records_left_d != '0) begin
        if (record_offset_d < REC_W'(REC_LEN)) begin
          case (record_offset_d)
            REC_W'(REC_HDR_END):   hdr_d   = word_shift_d;
            REC_W'(REC_SIZE_END):  size_d  = word_shift_d;
            REC_W'(REC_PROT_END):  prot_d  = word_shift_d;
            REC_W'(REC_DAYS_END):  days_d  = word_shift_d[15:0];
            REC_W'(REC_MINS_END):  mins_d  = word_shift_d[15:0];
            REC_W'(REC_TICKS_END): ticks_d = word_shift_d[15:0];
            REC_W'(REC_KIND):      ekind_d = data_byte_i;
            default: ;
          endcase
          record_offset_d = record_offset_d + REC_W'(1);
        end else if (record_offset_d == REC_W'(REC_LEN)) begin
          clamped_length_d = len;
          if (rec_end > SUM_W'(BLOCK_BYTES)) begin
            // record runs past the block end: drop it and the rest
            records_left_d  = '0;
            record_offset_d = '0;
          end else if (len == '0) begin
            res_o           = make_summary(hdr_d, size_d, prot_d, days_d, mins_d, ticks_d,
                                           ekind_d, len);
            res_valid_o     = 1'b1;
            records_left_d  = records_left_d - CNT_W'(1);
            record_offset_d = '0;
          end else begin
            record_offset_d = REC_W'(FIX_LEN);
          end
        end else if (record_offset_d < name_end) begin
          res_o           = '0;
          res_o.kind      = KIND_NAME;
          res_o.name_char = data_byte_i;
          res_valid_o     = 1'b1;
          if (record_offset_d + REC_W'(1) == name_end) begin
            done_pending_d  = 1'b1;
            records_left_d  = records_left_d - CNT_W'(1);
            record_offset_d = clamped_length_q[0] ? name_end : '0;
          end else begin
            record_offset_d = record_offset_d + REC_W'(1);
          end
        end else begin
          // pad byte
          record_offset_d = '0;
        end
      end

      byte_offset_d = (pos == OFF_W'(BLOCK_BYTES - 1)) ? '0 : pos + OFF_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q   <= '0;
      block_bad_q     <= 1'b0;
      records_left_q  <= '0;
      record_offset_q <= '0;
      done_pending_q  <= 1'b0;
    end else begin
      byte_offset_q   <= byte_offset_d;
      block_bad_q     <= block_bad_d;
      records_left_q  <= records_left_d;
      record_offset_q <= record_offset_d;
      done_pending_q  <= done_pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_shift_q     <= word_shift_d;
    hdr_q            <= hdr_d;
    size_q           <= size_d;
    prot_q           <= prot_d;
    days_q           <= days_d;
    mins_q           <= mins_d;
    ticks_q          <= ticks_d;
    ekind_q          <= ekind_d;
    clamped_length_q <= clamped_length_d;
  end

  // a pending summary is flushed by the next step, which never owes another
  `DCRP_ASSERT_NXT(a_pending_once, clk_i, rst_ni, step_i && done_pending_q, !done_pending_q)
  // a bad block never carries a record count
  `DCRP_ASSERT_IMP(a_bad_no_records, clk_i, rst_ni, block_bad_q, records_left_q == '0)

endmodule

>>> sv/dcrp_out_queue.sv
// ----------------------------------------------------------------------------
// dcrp_out_queue
// result register with a skid stage behind it
// ----------------------------------------------------------------------------
`include "dir_cache_record_parser_assert.svh"

module dcrp_out_queue import dcrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    head_valid_q, head_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop         = head_valid_q && !out_stall_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (!head_valid_q || pop) begin
      if (skid_valid_q) begin
        head_valid_d = 1'b1;
        head_d       = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        head_valid_d = push_i;
        head_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  `DCRP_ASSERT_IMP(a_skid_behind_head, clk_i, rst_ni, skid_valid_q, head_valid_q)
  `DCRP_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !skid_valid_q)

endmodule

>>> sv/dir_cache_record_parser.sv
// ----------------------------------------------------------------------------
// dir_cache_record_parser
// streaming parser for directory-cache blocks
// ----------------------------------------------------------------------------
// Takes a directory-cache block one byte per word and sustains one byte per
// clock while the output is not stalled; a byte's result passes the input
// register, then the result register, with the per-byte state update as the
// single logic stage in between. Byte 0 (block_start, or the wrap after the
// last byte of a block) clears the block state. The big-endian type word in
// bytes 0-3 is compared with cache_block_type and a mismatch gives one bad
// type word, after which the block is ignored. The record count comes from
// bytes 12-15 (top bit set means none) and the next-block pointer is
// reported at byte 19. From byte 24 records follow: each name byte is
// reported, then a record summary on the following byte, or on the length
// byte for an empty name. A record that would run past the block end ends
// record parsing for that block. cache_block_type may only be written while
// the parser is idle.
// ----------------------------------------------------------------------------
module dir_cache_record_parser import dcrp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               block_start_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         name_char_o,
  output logic [31:0]        header_block_o,
  output logic [31:0]        file_size_o,
  output logic [31:0]        protect_bits_o,
  output logic signed [15:0] date_days_o,
  output logic signed [15:0] date_mins_o,
  output logic signed [15:0] date_ticks_o,
  output logic signed [7:0]  entry_kind_o,
  output logic               is_plain_file_o,
  output logic               is_directory_o,
  output logic [4:0]         name_length_o
);

  // configuration register
  logic [31:0] cache_type_q;

  // input register
  logic       in_full_q;
  logic [7:0] byte_q;
  logic       start_q;

  logic    step;
  logic    q_ready;
  logic    res_valid;
  result_t res;
  result_t out_word;

  // the user must write the register only when idle; the block does not enforce it, so always ready
  assign cfg_ready_o = 1'b1;

  // a byte moves on whenever the skid stage has room
  assign step       = in_full_q && q_ready;
  assign in_stall_o = in_full_q && !q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_type_q <= CACHE_TYPE_RESET;
      in_full_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cache_type_q <= cfg_data_i;
      end
      if (!in_stall_o) begin
        in_full_q <= in_valid_i;
      end
    end
  end

  // payload taken with the word, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= data_byte_i;
      start_q <= block_start_i;
    end
  end

  // block and record state, at most one result word per byte
  dcrp_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .data_byte_i        (byte_q),
    .block_start_i      (start_q),
    .cache_block_type_i (cache_type_q),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  // result register plus skid stage
  dcrp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (q_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_word)
  );

  assign kind_o          = out_word.kind;
  assign name_char_o     = out_word.name_char;
  assign header_block_o  = out_word.header_block;
  assign file_size_o     = out_word.file_size;
  assign protect_bits_o  = out_word.protect_bits;
  assign date_days_o     = out_word.date_days;
  assign date_mins_o     = out_word.date_mins;
  assign date_ticks_o    = out_word.date_ticks;
  assign entry_kind_o    = out_word.entry_kind;
  assign is_plain_file_o = out_word.is_plain_file;
  assign is_directory_o  = out_word.is_directory;
  assign name_length_o   = out_word.name_length;

endmodule
